// ----- sv/assert_macros.svh -----
// shared assertion helpers, all sampled on the rising clock edge with reset masking
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every enabled clock edge
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mcpg_pkg.sv -----
`timescale 1ns / 1ps

package mcpg_pkg;

    // stream word layouts
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 96;
    localparam int OUT_TUSER_W  = 2;

    localparam int CX_LSB       = 0;
    localparam int CX_W         = 12;
    localparam int CY_LSB       = 12;
    localparam int CY_W         = 12;
    localparam int RAD_LSB      = 24;
    localparam int RAD_W        = 11;

    localparam int PIX_W        = 14;

    // decision value arithmetic
    localparam int DEC_W        = 16;
    localparam int DEC_INIT     = 3;
    localparam int DEC_DOWN_ADD = 10;
    localparam int DEC_FLAT_ADD = 6;
    localparam int DEC_SHIFT    = 2;

    // eight symmetric pixels per item
    localparam int OCT_W        = 3;
    localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

    localparam int QUEUE_DEPTH  = 2;

    // configuration register file
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_BASE   = 3'd0,
        REG_LINE_BYTES   = 3'd1,
        REG_PIXEL_BITS   = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4,
        REG_DRAW_COLOR   = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [14:0] line_bytes;
        logic [5:0]  pixel_bits;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [31:0] draw_color;
    } cfg_t;

    localparam logic [31:0] RST_FRAME_BASE   = 32'd0;
    localparam logic [14:0] RST_LINE_BYTES   = 15'd2000;
    localparam logic [5:0]  RST_PIXEL_BITS   = 6'd32;
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd500;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd500;
    localparam logic [31:0] RST_DRAW_COLOR   = 32'd255;

endpackage

// ----- sv/mcpg_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcpg_queue #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, !(push && full), "push into full queue")
    `ASSERT_ALWAYS(a_no_underflow, aclk, aresetn, !(pop && empty), "pop from empty queue")

endmodule

// ----- sv/mcpg_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcpg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mcpg_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [mcpg_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [4*COORD_BITS:0]                q_wdata
);

    localparam int CB = COORD_BITS;
    localparam int DW = mcpg_pkg::DEC_W;

    logic [CB-1:0] centre_col_reg, centre_col_next;
    logic [CB-1:0] centre_row_reg, centre_row_next;
    logic [CB-1:0] step_x_reg, step_x_next;
    logic [CB-1:0] step_y_reg, step_y_next;
    logic [DW-1:0] decision_reg, decision_next;
    logic          drawing_reg, drawing_next;

    logic          accept;
    logic          is_start;
    logic [CB-1:0] rad_c;
    logic [31:0]   x_inc_w;
    logic [31:0]   y_w;
    logic [31:0]   y_adj_w;
    logic          dec_pos;
    logic [DW-1:0] dec_step;
    logic [CB-1:0] x_new;
    logic [CB-1:0] y_new;
    logic          keep_going;
    logic          push_done;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (mcpg_pkg::opcode_t'(s_tuser[0]) == mcpg_pkg::OP_START);

    assign rad_c = CB'(s_tdata[mcpg_pkg::RAD_LSB +: mcpg_pkg::RAD_W]);

    // one octant step of the midpoint rule, decision kept modulo 2^16
    always_comb begin
        x_inc_w  = 32'(step_x_reg) + 32'd1;
        y_w      = {{(32-CB){step_y_reg[CB-1]}}, step_y_reg};
        dec_pos  = !decision_reg[DW-1] && (decision_reg != '0);
        y_adj_w  = dec_pos ? (y_w - 32'd1) : y_w;
        if (dec_pos) begin
            dec_step = decision_reg + DW'((x_inc_w - y_adj_w) << mcpg_pkg::DEC_SHIFT)
                       + DW'(mcpg_pkg::DEC_DOWN_ADD);
        end else begin
            dec_step = decision_reg + DW'(x_inc_w << mcpg_pkg::DEC_SHIFT)
                       + DW'(mcpg_pkg::DEC_FLAT_ADD);
        end
        x_new      = CB'(x_inc_w);
        y_new      = CB'(y_adj_w);
        keep_going = $signed({y_new[CB-1], y_new}) >= $signed({1'b0, x_new});
    end

    always_comb begin
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        decision_next   = decision_reg;
        drawing_next    = drawing_reg;
        q_push          = 1'b0;
        push_done       = 1'b0;
        if (accept) begin
            if (is_start) begin
                centre_col_next = CB'(s_tdata[mcpg_pkg::CX_LSB +: mcpg_pkg::CX_W]);
                centre_row_next = CB'(s_tdata[mcpg_pkg::CY_LSB +: mcpg_pkg::CY_W]);
                step_x_next     = '0;
                step_y_next     = rad_c;
                decision_next   = DW'(32'(mcpg_pkg::DEC_INIT) - (32'(rad_c) << 1));
                drawing_next    = 1'b1;
                q_push          = 1'b1;
            end else if (drawing_reg) begin
                step_x_next     = x_new;
                step_y_next     = y_new;
                decision_next   = dec_step;
                drawing_next    = keep_going;
                q_push          = 1'b1;
                push_done       = !keep_going;
            end
        end
        // record layout from lsb: cx, cy, x, y, done
        q_wdata = {push_done, step_y_next, step_x_next, centre_row_next, centre_col_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            drawing_reg    <= 1'b0;
        end else begin
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            decision_reg   <= decision_next;
            drawing_reg    <= drawing_next;
        end
    end

    `ASSERT_NEXT(a_done_ends_circle, aclk, aresetn, q_push && push_done, !drawing_reg,
        "circle still active after its final step")
    `ASSERT_IMPLY(a_push_only_on_accept, aclk, aresetn, q_push, accept,
        "record queued without an accepted word")

endmodule

// ----- sv/mcpg_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcpg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mcpg_pkg::cfg_t                       cfg,
    input  logic                                 q_empty,
    input  logic [4*COORD_BITS:0]                q_rdata,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mcpg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [mcpg_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int PW = COORD_BITS + 2;
    localparam int XW = mcpg_pkg::PIX_W;
    localparam int OW = mcpg_pkg::OCT_W;

    logic [CB-1:0] rec_cx, rec_cy, rec_x, rec_y;
    logic          rec_done;

    logic          adv;
    logic [OW-1:0] oct_reg, oct_next;

    logic signed [PW-1:0] xe, ye, cxe, cye, off_a, off_b, px_c, py_c;

    // stage 1: pixel coordinates
    logic                 s1_valid_reg;
    logic signed [PW-1:0] s1_px_reg, s1_py_reg;
    logic                 s1_last_reg, s1_done_reg;

    // stage 2: address products and bounds check
    logic [31:0]   px32, py32;
    logic          s2_valid_reg;
    logic [31:0]   s2_row_reg, s2_col_reg;
    logic [XW-1:0] s2_px_reg, s2_py_reg;
    logic          s2_inb_reg, s2_last_reg, s2_done_reg;

    // output register
    logic          out_valid_reg;
    logic [31:0]   out_addr_reg;
    logic [XW-1:0] out_px_reg, out_py_reg;
    logic          out_inb_reg, out_last_reg, out_done_reg;

    assign {rec_done, rec_y, rec_x, rec_cy, rec_cx} = q_rdata;

    // whole pipeline moves together when the output slot frees up
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && !q_empty && (oct_reg == mcpg_pkg::OCT_LAST);

    always_comb begin
        oct_next = oct_reg;
        if (adv && !q_empty) begin
            oct_next = oct_reg + OW'(1);
        end
    end

    // octant select: bit 2 swaps x and y, bit 0 negates column, bit 1 negates row
    always_comb begin
        xe    = $signed({2'b00, rec_x});
        ye    = $signed({rec_y[CB-1], rec_y[CB-1], rec_y});
        cxe   = $signed({2'b00, rec_cx});
        cye   = $signed({2'b00, rec_cy});
        off_a = oct_reg[2] ? ye : xe;
        off_b = oct_reg[2] ? xe : ye;
        px_c  = oct_reg[0] ? (cxe - off_a) : (cxe + off_a);
        py_c  = oct_reg[1] ? (cye - off_b) : (cye + off_b);
    end

    assign px32 = {{(32-PW){s1_px_reg[PW-1]}}, s1_px_reg};
    assign py32 = {{(32-PW){s1_py_reg[PW-1]}}, s1_py_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            oct_reg <= oct_next;
            if (adv) begin
                s1_valid_reg  <= !q_empty;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_px_reg   <= px_c;
            s1_py_reg   <= py_c;
            s1_last_reg <= (oct_reg == mcpg_pkg::OCT_LAST);
            s1_done_reg <= (oct_reg == mcpg_pkg::OCT_LAST) && rec_done;

            s2_row_reg  <= py32 * {17'd0, cfg.line_bytes};
            s2_col_reg  <= px32 * {29'd0, cfg.pixel_bits[5:3]};
            s2_px_reg   <= px32[XW-1:0];
            s2_py_reg   <= py32[XW-1:0];
            s2_inb_reg  <= !s1_px_reg[PW-1] && !s1_py_reg[PW-1]
                           && (px32 < {19'd0, cfg.frame_width})
                           && (py32 < {19'd0, cfg.frame_height});
            s2_last_reg <= s1_last_reg;
            s2_done_reg <= s1_done_reg;

            out_addr_reg <= cfg.frame_base + s2_row_reg + s2_col_reg;
            out_px_reg   <= s2_px_reg;
            out_py_reg   <= s2_py_reg;
            out_inb_reg  <= s2_inb_reg;
            out_last_reg <= s2_last_reg;
            out_done_reg <= s2_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_inb_reg};
    assign m_tdata  = {4'd0, cfg.draw_color, out_addr_reg, out_py_reg, out_px_reg};

    `ASSERT_IMPLY(a_done_on_last, aclk, aresetn, out_valid_reg && out_done_reg, out_last_reg,
        "circle end flagged away from the eighth pixel")
    `ASSERT_NEXT(a_pop_wraps_octant, aclk, aresetn, q_pop, oct_reg == '0,
        "octant counter not back at start after a record")

endmodule

// ----- sv/midpoint_circle_pixel_generator.sv -----
`timescale 1ns / 1ps

// Midpoint circle pixel generator. A start word (tuser = 0) loads the centre and
// radius and produces the eight symmetric pixels of (0, r); each step word
// (tuser = 1) advances one octant step and produces eight more, the last of them
// with circle_done set once y drops below x. Step words with no circle active are
// taken and dropped with no output. Every pixel word carries its coordinates, the
// byte address frame_base + row*line_bytes + col*(pixel_bits/8) modulo 2^32, the
// draw colour and an in-bounds flag; off-frame pixels are still sent. Throughput
// is one pixel word per cycle while m_tready is high and records are queued. The
// input side runs ahead through a two-entry record queue; the record being walked
// keeps its entry until its eighth pixel is issued, so one more word can wait
// behind it before s_tready drops. With the back idle, the first pixel of an
// accepted word passes through the record queue, stage 1, stage 2 and the output
// register. Configuration registers may only be written while no pixels are
// outstanding.

module midpoint_circle_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [mcpg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mcpg_pkg::CFG_DATA_W-1:0]      cfg_wr_data,

    // command words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata from lsb: center_x[11:0], center_y[23:12], radius[34:24], zero pad
    input  logic [mcpg_pkg::IN_TDATA_W-1:0]      s_tdata,
    // tuser: opcode (0 start, 1 step)
    input  logic [mcpg_pkg::IN_TUSER_W-1:0]      s_tuser,

    // pixel words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata from lsb: pixel_x[13:0], pixel_y[27:14], pixel_address[59:28],
    // pixel_color[91:60], zero pad
    output logic [mcpg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser from lsb: in_bounds, circle_done
    output logic [mcpg_pkg::OUT_TUSER_W-1:0]     m_tuser,
    // tlast: eighth pixel of a word's run
    output logic                                 m_tlast
);

    // one queued record: centre, current x and y, and the end-of-circle mark
    localparam int REC_W = 4 * COORD_BITS + 1;

    mcpg_pkg::cfg_t cfg_reg, cfg_next;

    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    // register file, to be written by the user only between circles; the block itself does not enforce this
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (mcpg_pkg::cfg_idx_t'(cfg_addr))
                mcpg_pkg::REG_FRAME_BASE:   cfg_next.frame_base   = cfg_wr_data;
                mcpg_pkg::REG_LINE_BYTES:   cfg_next.line_bytes   = cfg_wr_data[14:0];
                mcpg_pkg::REG_PIXEL_BITS:   cfg_next.pixel_bits   = cfg_wr_data[5:0];
                mcpg_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_wr_data[12:0];
                mcpg_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_wr_data[12:0];
                mcpg_pkg::REG_DRAW_COLOR:   cfg_next.draw_color   = cfg_wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base   <= mcpg_pkg::RST_FRAME_BASE;
            cfg_reg.line_bytes   <= mcpg_pkg::RST_LINE_BYTES;
            cfg_reg.pixel_bits   <= mcpg_pkg::RST_PIXEL_BITS;
            cfg_reg.frame_width  <= mcpg_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= mcpg_pkg::RST_FRAME_HEIGHT;
            cfg_reg.draw_color   <= mcpg_pkg::RST_DRAW_COLOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: takes command words, runs the midpoint recurrence, queues records
    mcpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // decouples command intake from pixel drain
    mcpg_queue #(
        .WIDTH (REC_W),
        .DEPTH (mcpg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // back: walks the eight octants of each record and builds pixel words
    mcpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
